@@ hdl/a2ab_pkg.sv @@
// Shared types and constants for the avcC to Annex B converter.
package a2ab_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // Header check constants
    localparam logic [7:0] HDR_VERSION   = 8'h01;
    localparam logic [5:0] HDR_LEN_ONES  = 6'h3F;
    localparam logic [2:0] HDR_SPS_ONES  = 3'h7;
    localparam logic [2:0] HDR_POS_LEN   = 3'd4;
    localparam logic [2:0] HDR_POS_COUNT = 3'd5;

    localparam int CNT_W   = 25;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Start code length in bytes
    localparam logic [CNT_W-1:0] SC_BYTES = CNT_W'(4);

    // Parser phases, one-hot
    typedef enum logic [5:0] {
        PH_WAIT   = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_COUNT2 = 6'b100000
    } t_phase;

    // Commands from the parser to the emitter
    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_START  = 2'd1,
        OP_REJECT = 2'd2,
        OP_DONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             done;   // completion follows the bytes
        logic [7:0]       data;
        logic [CNT_W-1:0] count;  // total bytes once this command is emitted
    } t_cmd;

    // Queue status seen by the emitter
    typedef struct packed {
        logic empty;
        t_cmd head;
    } t_qstat;

endpackage

@@ hdl/a2ab_front.sv @@
// Record parser: walks the avcC fields and issues emit commands.
module a2ab_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_record_start,
    input  logic           i_q_full,
    output logic           o_push,
    output a2ab_pkg::t_cmd o_cmd
);
    import a2ab_pkg::*;

    t_phase           r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic             r_ok, n_ok;
    logic [7:0]       r_units, n_units;
    logic [15:0]      r_len, n_len;
    logic             r_second, n_second;
    logic [CNT_W-1:0] r_count, n_count;

    logic             take;
    logic             ok_now;
    logic [15:0]      full_len;
    logic [7:0]       units_dec;
    logic [15:0]      len_dec;
    logic             push;
    t_cmd             cmd;

    assign o_ready   = !i_q_full;
    assign take      = i_valid && !i_q_full;
    assign full_len  = {r_len[15:8], i_in_byte};
    assign units_dec = r_units - 8'd1;
    assign len_dec   = r_len - 16'd1;
    assign ok_now    = r_ok && !((r_pos == HDR_POS_LEN) && (i_in_byte[7:2] != HDR_LEN_ONES));

    // Next-state and command decode for one byte
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_ok     = r_ok;
        n_units  = r_units;
        n_len    = r_len;
        n_second = r_second;
        n_count  = r_count;
        push     = 1'b0;
        cmd.op   = OP_DATA;
        cmd.done = 1'b0;
        cmd.data = i_in_byte;
        cmd.count = r_count;

        if (i_record_start) begin
            n_phase  = PH_HEADER;
            n_pos    = 3'd1;
            n_ok     = (i_in_byte == HDR_VERSION);
            n_units  = '0;
            n_len    = '0;
            n_second = 1'b0;
            n_count  = '0;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_ok = ok_now;
                    if (r_pos == HDR_POS_COUNT) begin
                        if (!ok_now || (i_in_byte[7:5] != HDR_SPS_ONES)) begin
                            n_ok    = 1'b0;
                            push    = 1'b1;
                            cmd.op  = OP_REJECT;
                            n_phase = PH_WAIT;
                        end else begin
                            n_units = {3'b000, i_in_byte[4:0]};
                            if (i_in_byte[4:0] == 5'd0) begin
                                n_second = 1'b1;
                                n_phase  = PH_COUNT2;
                            end else begin
                                n_phase = PH_LEN_HI;
                            end
                        end
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_LEN_HI: begin
                    n_len   = {i_in_byte, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len     = full_len;
                    n_count   = r_count + SC_BYTES;
                    push      = 1'b1;
                    cmd.op    = OP_START;
                    cmd.count = n_count;
                    if (full_len == 16'd0) begin
                        // empty unit: the start code alone closes it
                        n_units = units_dec;
                        if (units_dec != 8'd0) begin
                            n_phase = PH_LEN_HI;
                        end else if (!r_second) begin
                            n_second = 1'b1;
                            n_phase  = PH_COUNT2;
                        end else begin
                            cmd.done = 1'b1;
                            n_phase  = PH_WAIT;
                        end
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_len     = len_dec;
                    n_count   = r_count + CNT_W'(1);
                    push      = 1'b1;
                    cmd.op    = OP_DATA;
                    cmd.count = n_count;
                    if (len_dec == 16'd0) begin
                        n_units = units_dec;
                        if (units_dec != 8'd0) begin
                            n_phase = PH_LEN_HI;
                        end else if (!r_second) begin
                            n_second = 1'b1;
                            n_phase  = PH_COUNT2;
                        end else begin
                            cmd.done = 1'b1;
                            n_phase  = PH_WAIT;
                        end
                    end
                end
                PH_COUNT2: begin
                    n_units = i_in_byte;
                    if (i_in_byte == 8'd0) begin
                        // second list is empty: complete now
                        push    = 1'b1;
                        cmd.op  = OP_DONE;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign o_push = take && push;
    assign o_cmd  = cmd;

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_pos    <= '0;
            r_ok     <= 1'b1;
            r_units  <= '0;
            r_len    <= '0;
            r_second <= 1'b0;
            r_count  <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_ok     <= n_ok;
            r_units  <= n_units;
            r_len    <= n_len;
            r_second <= n_second;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/a2ab_fifo.sv @@
// Short command queue between the parser and the emitter.
module a2ab_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  a2ab_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output a2ab_pkg::t_qstat o_stat
);
    import a2ab_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;

    assign o_full       = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (Q_AW+1)'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

@@ hdl/a2ab_back.sv @@
// Emitter: expands queued commands into result items with an output register.
module a2ab_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  a2ab_pkg::t_qstat       i_stat,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_out_byte,
    output logic [1:0]             o_kind,
    output logic [a2ab_pkg::CNT_W-1:0] o_bytes_written,
    output logic                   o_run_last
);
    import a2ab_pkg::*;

    logic             r_valid;
    logic [7:0]       r_byte, n_byte;
    logic [1:0]       r_kind, n_kind;
    logic [CNT_W-1:0] r_bw, n_bw;
    logic             r_last;
    logic [2:0]       r_step;
    logic [2:0]       last_step;
    logic             advance;
    logic             fire;
    t_cmd             head;

    assign head    = i_stat.head;
    assign advance = !r_valid || i_ready;
    assign fire    = advance && !i_stat.empty;
    assign o_pop   = fire && (r_step == last_step);

    // Result for the current step of the head command
    always_comb begin
        last_step = 3'd0;
        n_byte    = 8'h00;
        n_kind    = KIND_DATA;
        case (head.op)
            OP_START: begin
                last_step = head.done ? 3'd4 : 3'd3;
                if (r_step == 3'd4) begin
                    n_kind = KIND_DONE;
                end else if (r_step == 3'd3) begin
                    n_byte = 8'h01;
                end
            end
            OP_DATA: begin
                last_step = head.done ? 3'd1 : 3'd0;
                if (r_step == 3'd1) begin
                    n_kind = KIND_DONE;
                end else begin
                    n_byte = head.data;
                end
            end
            OP_REJECT: begin
                n_kind = KIND_REJECT;
            end
            OP_DONE: begin
                n_kind = KIND_DONE;
            end
            default: begin
                n_kind = KIND_DATA;
            end
        endcase
        n_bw = (n_kind == KIND_DONE) ? head.count : '0;
    end

    // Step counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (advance) begin
            r_valid <= !i_stat.empty;
            if (fire) begin
                r_step <= o_pop ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= n_byte;
            r_kind <= n_kind;
            r_bw   <= n_bw;
            r_last <= o_pop;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_byte      = r_byte;
    assign o_kind          = r_kind;
    assign o_bytes_written = r_bw;
    assign o_run_last      = r_last;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stat.empty |-> r_step <= last_step)
        else $error("emit step beyond command length");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind != KIND_DATA)) |-> r_last)
        else $error("status result not last of its request");

    a_data_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind != KIND_DONE)) |-> (r_bw == '0))
        else $error("byte count on non-completion result");

endmodule

@@ hdl/avcc_config_to_annexb.sv @@
// Top level of the avcC to Annex B converter.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_byte, i_record_start
//  out     | output    | o_out_valid / i_out_ready  | o_out_byte, o_kind,
//          |           |                            | o_bytes_written, o_run_last
//
//  The parser takes one request per cycle while the 4-entry command queue has room.
//  The emitter gives one result per cycle while the output is ready; a data byte makes
//  1 result (2 with completion), a start code 4 (5 with completion), so bursts drain
//  through the queue. Results pass through the command queue, then the output register.
//  Reset (synchronous, active low) empties the queue and returns the parser to waiting.
//  A stalled output holds its register; the parser stops only when the queue is full.
module avcc_config_to_annexb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_record_start,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_byte,
    output logic [1:0]                 o_kind,
    output logic [a2ab_pkg::CNT_W-1:0] o_bytes_written,
    output logic                       o_run_last
);
    import a2ab_pkg::*;

    logic   q_full;
    logic   push;
    logic   pop;
    t_cmd   cmd;
    t_qstat qstat;

    a2ab_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_record_start (i_record_start),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    a2ab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_stat  (qstat)
    );

    a2ab_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stat          (qstat),
        .o_pop           (pop),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_bytes_written (o_bytes_written),
        .o_run_last      (o_run_last)
    );

endmodule

@@ sim/tb_avcc_config_to_annexb.sv @@
// Self-checking testbench for the avcC to Annex B converter.
`timescale 1ns / 100ps

module tb_avcc_config_to_annexb;
    import a2ab_pkg::*;

    localparam int          LIVE_ITEMS  = 130;
    localparam int          IDLE_PCT    = 18;
    localparam int          QUIET_FROM  = 40;
    localparam int          QUIET_TO    = 90;
    localparam int          DRAIN       = 20;
    localparam int          STALL_LIMIT = 4000;
    localparam int          MAX_REPORTS = 10;
    localparam logic [31:0] START_CODE  = 32'h0000_0001;

    // One record byte as it goes into the converter
    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } t_rec_byte;

    // One Annex B result
    typedef struct packed {
        logic [7:0]       value;
        logic [1:0]       kind;
        logic [CNT_W-1:0] total;
        logic             last;
    } t_annexb_out;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_in_byte = 8'h00;
    logic             i_record_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [7:0]       o_out_byte;
    logic [1:0]       o_kind;
    logic [CNT_W-1:0] o_bytes_written;
    logic             o_run_last;

    t_rec_byte   avcc_bytes[$];
    t_annexb_out annexb_expected[$];
    t_annexb_out step_out[$];
    t_annexb_out got_res;
    t_annexb_out exp_res;

    int live_count   = 0;
    int sent_count   = 0;
    int errors       = 0;
    int stall_cycles = 0;
    logic in_taken   = 1'b0;
    logic quiet;

    // Converter state as the testbench sees it
    t_phase           ph = PH_WAIT;
    logic [2:0]       hdr_pos = 3'd0;
    logic             hdr_ok = 1'b1;
    logic [7:0]       units_left = 8'd0;
    logic [15:0]      nal_left = 16'd0;
    logic             pps_list = 1'b0;
    logic [CNT_W-1:0] annexb_total = '0;

    avcc_config_to_annexb uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_record_start (i_record_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_kind         (o_kind),
        .o_bytes_written(o_bytes_written),
        .o_run_last     (o_run_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    task automatic emit_result(input logic [7:0] b, input logic [1:0] k,
                               input logic [CNT_W-1:0] c);
        step_out.push_back('{value: b, kind: k, total: c, last: 1'b0});
        if (k == KIND_DATA) annexb_total = annexb_total + CNT_W'(1);
    endtask

    // SPS list moves on to the PPS count; PPS list completes the record
    task automatic close_list();
        if (!pps_list) begin
            pps_list = 1'b1;
            ph = PH_COUNT2;
        end else begin
            emit_result(8'h00, KIND_DONE, annexb_total);
            ph = PH_WAIT;
        end
    endtask

    task automatic unit_finished();
        units_left = units_left - 8'd1;
        if (units_left == 8'd0) close_list();
        else ph = PH_LEN_HI;
    endtask

    task automatic parse_avcc_byte(input logic [7:0] b, input logic first);
        step_out.delete();
        if (first) begin
            ph           = PH_HEADER;
            hdr_pos      = 3'd1;
            hdr_ok       = (b == HDR_VERSION);
            units_left   = 8'd0;
            nal_left     = 16'd0;
            pps_list     = 1'b0;
            annexb_total = '0;
        end else begin
            case (ph)
                PH_HEADER: begin
                    if (hdr_pos == HDR_POS_LEN && b[7:2] != HDR_LEN_ONES) hdr_ok = 1'b0;
                    if (hdr_pos == HDR_POS_COUNT) begin
                        if (b[7:5] != HDR_SPS_ONES) hdr_ok = 1'b0;
                        if (!hdr_ok) begin
                            emit_result(8'h00, KIND_REJECT, '0);
                            ph = PH_WAIT;
                        end else begin
                            units_left = {3'b000, b[4:0]};
                            if (units_left == 8'd0) close_list();
                            else ph = PH_LEN_HI;
                        end
                    end else begin
                        hdr_pos = hdr_pos + 3'd1;
                    end
                end
                PH_LEN_HI: begin
                    nal_left = {b, 8'h00};
                    ph = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    nal_left[7:0] = b;
                    for (int i = 0; i < 4; i++)
                        emit_result(START_CODE[31-8*i -: 8], KIND_DATA, '0);
                    if (nal_left == 16'd0) unit_finished();
                    else ph = PH_DATA;
                end
                PH_DATA: begin
                    emit_result(b, KIND_DATA, '0);
                    nal_left = nal_left - 16'd1;
                    if (nal_left == 16'd0) unit_finished();
                end
                PH_COUNT2: begin
                    units_left = b;
                    if (units_left == 8'd0) close_list();
                    else ph = PH_LEN_HI;
                end
                default: ;
            endcase
        end
        if (step_out.size() != 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) annexb_expected.push_back(step_out[i]);
    endtask

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic first, input bit counted);
        avcc_bytes.push_back('{value: b, first: first});
        if (counted) live_count++;
    endtask

    // Record with random content; an intact one is short and complete,
    // otherwise counts and lengths are wild and the record is cut at cap bytes
    task automatic build_record(input bit intact, input int cap);
        t_rec_byte rec[$];
        int        n_units;
        int        nal_len;
        rec.push_back('{value: HDR_VERSION, first: 1'b1});
        for (int i = 0; i < 3; i++) rec.push_back('{value: 8'($urandom), first: 1'b0});
        rec.push_back('{value: {HDR_LEN_ONES, 2'($urandom)}, first: 1'b0});
        n_units = intact ? $urandom_range(0, 2) : $urandom_range(0, 31);
        rec.push_back('{value: {HDR_SPS_ONES, 5'(n_units)}, first: 1'b0});
        for (int lst = 0; lst < 2; lst++) begin
            if (lst == 1) begin
                n_units = intact ? $urandom_range(0, 2) : $urandom_range(0, 255);
                rec.push_back('{value: 8'(n_units), first: 1'b0});
            end
            for (int u = 0; u < n_units && rec.size() < cap; u++) begin
                nal_len = intact ? $urandom_range(0, 4) : $urandom_range(0, 65535);
                rec.push_back('{value: 8'(nal_len >> 8), first: 1'b0});
                rec.push_back('{value: 8'(nal_len), first: 1'b0});
                for (int k = 0; k < nal_len && rec.size() < cap; k++)
                    rec.push_back('{value: 8'($urandom), first: 1'b0});
            end
        end
        for (int i = 0; i < rec.size() && i < cap; i++)
            queue_byte(rec[i].value, rec[i].first, 1'b1);
    endtask

    // Header with one of the three checks failing
    task automatic build_bad_header();
        logic [7:0] hb[6];
        int         fault;
        hb[0] = HDR_VERSION;
        for (int i = 1; i < 4; i++) hb[i] = 8'($urandom);
        hb[4] = {HDR_LEN_ONES, 2'($urandom)};
        hb[5] = {HDR_SPS_ONES, 5'($urandom)};
        fault = $urandom_range(0, 2);
        case (fault)
            0: hb[0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(2, 255));
            1: hb[4] = 8'($urandom_range(0, 8'hFB));
            default: hb[5] = 8'($urandom_range(0, 8'hDF));
        endcase
        for (int i = 0; i < 6; i++) queue_byte(hb[i], i == 0, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Sequence: stimulus, reset, wait for drain, verdict
    // ---------------------------------------------------------------
    initial begin
        int r;
        // byte before any record: ignored
        queue_byte(8'hFF, 1'b0, 1'b0);
        // empty SPS and PPS lists, completes with zero bytes
        queue_byte(8'h01, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h80, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'hE0, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        // byte after completion: ignored
        queue_byte(8'h55, 1'b0, 1'b0);
        // length byte check fails
        queue_byte(8'h01, 1'b1, 1'b1);
        queue_byte(8'h12, 1'b0, 1'b1);
        queue_byte(8'h34, 1'b0, 1'b1);
        queue_byte(8'h56, 1'b0, 1'b1);
        queue_byte(8'hFB, 1'b0, 1'b1);
        queue_byte(8'hE1, 1'b0, 1'b1);
        // byte after reject: ignored
        queue_byte(8'h33, 1'b0, 1'b0);
        // zero-length SPS, then a PPS of three data bytes of which only the first is sent here
        queue_byte(8'h01, 1'b1, 1'b1);
        queue_byte(8'hAA, 1'b0, 1'b1);
        queue_byte(8'h55, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFC, 1'b0, 1'b1);
        queue_byte(8'hE1, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h03, 1'b0, 1'b1);
        queue_byte(8'hA5, 1'b0, 1'b1);

        // random part: mostly complete records
        while (live_count < LIVE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65) build_record(1'b1, 1 << 30);
            else if (r < 80) build_bad_header();
            else if (r < 93) build_record(1'b0, $urandom_range(2, 14));
            else repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0, 1'b0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (avcc_bytes.size() != 0 || i_in_valid || annexb_expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: requests and output ready change on the falling edge
    // ---------------------------------------------------------------
    assign quiet = (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);

    always @(negedge i_clk) begin
        t_rec_byte req;
        if (i_rst_n) begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!i_in_valid || in_taken) begin
                if (avcc_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    req = avcc_bytes.pop_front();
                    i_in_byte      <= req.value;
                    i_record_start <= req.first;
                    i_in_valid     <= 1'b1;
                    sent_count++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted requests, check accepted results
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) parse_avcc_byte(i_in_byte, i_record_start);

            if (o_out_valid && i_out_ready) begin
                got_res = '{value: o_out_byte, kind: o_kind, total: o_bytes_written,
                            last: o_run_last};
                if (annexb_expected.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result byte %h kind %0d count %0d last %b",
                                 $time, got_res.value, got_res.kind, got_res.total,
                                 got_res.last);
                end else begin
                    exp_res = annexb_expected.pop_front();
                    if (got_res !== exp_res) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: mismatch exp byte %h kind %0d count %0d last %b,",
                                      " got byte %h kind %0d count %0d last %b"},
                                     $time, exp_res.value, exp_res.kind, exp_res.total,
                                     exp_res.last, got_res.value, got_res.kind,
                                     got_res.total, got_res.last);
                    end
                end
            end

            // watchdog on cycles without any handshake
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

endmodule
